// ===== rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

  // Operation codes carried on the command field.
  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lkv_cmd_t;

  localparam int CAP_W = 5;
  localparam int DATA_W = 32;

  // Capacity after reset, and read data returned by a get that misses.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_DATA = 32'hFFFF_FFFF;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic match_en;
    logic apply_en;
    logic trim_en;
    logic out_load;
  } lkv_ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_put;
  } lkv_stat_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// The controller runs match, update and result steps in turn for each item, and
// for a put a capacity-eviction step between update and result; a new item is
// accepted only after the result step of the last one.
// A waiting result does not block the next item until the result step.
// Reset (synchronous, active low) empties the store and sets capacity to 16.
`timescale 1ns / 1ps

module lru_key_value_cache import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_store_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic signed [31:0] out_read_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_active_capacity
);

  lkv_ctrl_t ctrl;
  lkv_stat_t stat;

  // The capacity register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lkv_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .stat                (stat),
    .in_command          (in_command),
    .in_lookup_key       (in_lookup_key),
    .in_store_value      (in_store_value),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_active_capacity (cfg_active_capacity),
    .out_found           (out_found),
    .out_read_data       (out_read_data)
  );

endmodule

// ===== rtl/lkv_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lkv_ctrl.sv =====
// Sequencing state machine for the LRU key/value cache.
// Depends on lkv_pkg for the command and status structs.
`timescale 1ns / 1ps

module lkv_ctrl import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  lkv_stat_t stat,
  output lkv_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY,
    S_TRIM,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Commands follow from the current state, with in_valid and output space.
  always_comb begin
    ctrl.load_item = (state_r == S_IDLE) && in_valid;
    ctrl.match_en  = (state_r == S_MATCH);
    ctrl.apply_en  = (state_r == S_APPLY);
    ctrl.trim_en   = (state_r == S_TRIM);
    ctrl.out_load  = (state_r == S_DONE) && out_free;
  end

  // Next state: puts take an extra step for the over-capacity eviction.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MATCH;
      end
      S_MATCH: state_nxt = S_APPLY;
      S_APPLY: begin
        state_nxt = stat.is_put ? S_TRIM : S_DONE;
      end
      S_TRIM: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid is set on a result load and cleared once the transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A result is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  // Every accepted item reaches the eviction or result step after its match and update steps.
  a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_item |=> ##2 (state_r == S_TRIM || state_r == S_DONE))
    else $error("item did not reach completion on schedule");

  // An eviction step is only taken for a put.
  a_trim_put: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.trim_en |-> $past(stat.is_put))
    else $error("eviction step entered for a get");

endmodule

// ===== rtl/lkv_dpath.sv =====
// Datapath of the LRU key/value cache: key CAM, recency ranks, value RAM.
// Depends on lkv_pkg and instantiates lkv_ram.
`timescale 1ns / 1ps

module lkv_dpath import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lkv_ctrl_t          ctrl,
  output lkv_stat_t          stat,
  input  logic               in_command,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_store_value,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_active_capacity,
  output logic               out_found,
  output logic signed [31:0] out_read_data
);

  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_ENTRIES);

  // Item registers.
  lkv_cmd_t          cmd_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] val_r;
  logic [CAP_W-1:0]  cap_r;

  // Entry state.
  logic [DATA_W-1:0]      keys_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW-1:0]          rank_r [MAX_ENTRIES];
  logic [IW-1:0]          rank_nxt [MAX_ENTRIES];
  logic [CW-1:0]          count_r, count_nxt;

  // Match results.
  logic                   hit_r, full_r;
  logic [MAX_ENTRIES-1:0] slot_oh_r;
  logic [IW-1:0]          slot_idx_r;
  logic [IW-1:0]          hit_rank_r;

  logic [MAX_ENTRIES-1:0] hit_oh, victim_oh, free_oh, slot_oh;
  logic [IW-1:0]          slot_idx, hit_rank, last_rank;
  logic                   hit, full;
  logic [CMPW-1:0]        cap_eff;
  logic                   over_cap;

  logic [DATA_W-1:0] ram_rdata;
  logic              ram_we, ram_re;

  logic              out_found_r;
  logic [DATA_W-1:0] out_data_r;

  assign stat.is_put = (cmd_r == CMD_PUT);

  // Capture the accepted transaction.
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      cmd_r <= lkv_cmd_t'(in_command);
      key_r <= in_lookup_key;
      val_r <= in_store_value;
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_active_capacity;
    end
  end

  // Parallel key compare, least-recent lane and lowest free lane.
  always_comb begin
    last_rank = IW'(count_r - CW'(1));
    hit_oh    = '0;
    victim_oh = '0;
    hit_rank  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_oh[i]    = valid_r[i] && (keys_r[i] == key_r);
      victim_oh[i] = valid_r[i] && (rank_r[i] == last_rank);
      if (hit_oh[i]) hit_rank = hit_rank | rank_r[i];
    end
    free_oh = ~valid_r & (valid_r + MAX_ENTRIES'(1));
    full    = &valid_r;
    hit     = |hit_oh;
    slot_oh = hit ? hit_oh : (full ? victim_oh : free_oh);
    slot_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_oh[i]) slot_idx = slot_idx | IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.match_en) begin
      hit_r      <= hit;
      full_r     <= full;
      slot_oh_r  <= slot_oh;
      slot_idx_r <= slot_idx;
      hit_rank_r <= hit_rank;
    end
  end

  // Effective capacity is clamped to the store size.
  always_comb begin
    cap_eff  = (CMPW'(cap_r) > MAX_CMP) ? MAX_CMP : CMPW'(cap_r);
    over_cap = CMPW'(count_r) > cap_eff;
  end

  // Recency and occupancy update: touch on a hit, insert on a put miss,
  // then drop the least recent entry when a put leaves the store over capacity.
  // A put that replaced an entry of a full store has already evicted one.
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (ctrl.apply_en) begin
      if (hit_r) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_oh_r[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
      end else if (cmd_r == CMD_PUT) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_oh_r[i]) begin
            valid_nxt[i] = 1'b1;
            rank_nxt[i]  = '0;
          end else if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        if (!full_r) count_nxt = count_r + CW'(1);
      end
    end else if (ctrl.trim_en && over_cap && (hit_r || !full_r)) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (victim_oh[i]) begin
          valid_nxt[i] = 1'b0;
          rank_nxt[i]  = '0;
        end
      end
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // Key store: a put that misses writes its key into the chosen lane.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (ctrl.apply_en && (cmd_r == CMD_PUT) && !hit_r && slot_oh_r[i]) begin
        keys_r[i] <= key_r;
      end
    end
  end

  // Value store: puts write the slot, get hits read it.
  assign ram_we = ctrl.apply_en && (cmd_r == CMD_PUT);
  assign ram_re = ctrl.apply_en && (cmd_r == CMD_GET) && hit_r;

  lkv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx_r),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (slot_idx_r),
    .rdata (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_found_r <= hit_r;
      if (cmd_r == CMD_PUT) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= hit_r ? ram_rdata : MISS_DATA;
      end
    end
  end

  assign out_found     = out_found_r;
  assign out_read_data = out_data_r;

  // The fill count always matches the number of valid entries.
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid entries");

  // Keys of valid entries are unique, so at most one lane matches.
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.apply_en |-> $onehot0(slot_oh_r) && (!hit_r || $onehot(slot_oh_r)))
    else $error("multiple lanes selected for one transaction");

  // A put that misses in a store with a free lane grows the count by one.
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.apply_en && (cmd_r == CMD_PUT) && !hit_r && !full_r)
      |=> (int'(count_r) == int'($past(count_r)) + 1))
    else $error("insert did not grow the entry count");

endmodule

// ===== sim/lru_key_value_cache_checker.sv =====
// Checker for the LRU key/value cache: watches the input, result and capacity
// channels, predicts every result and compares it. Depends on lkv_pkg.
`timescale 1ns / 1ps

module lru_key_value_cache_checker import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_lookup_key,
  input  logic [31:0] in_store_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_found,
  input  logic [31:0] out_read_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_active_capacity,
  output int          mismatch_count,
  output int          pending_results
);

  typedef struct packed {
    logic        found;
    logic [31:0] data;
  } cache_result_t;

  // Shadow copy of the store, its recency order and the capacity register.
  logic [31:0]  slot_key   [MAX_ENTRIES];
  logic [31:0]  slot_value [MAX_ENTRIES];
  logic         slot_valid [MAX_ENTRIES];
  int           slot_rank  [MAX_ENTRIES];
  int           entry_total;
  logic [4:0]   capacity;

  cache_result_t expected_results[$];

  // Make slot s the most recent; entries more recent than it age by one.
  function automatic void promote(int s);
    int i;
    for (i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  function automatic int oldest_slot();
    int i;
    int best;
    best = -1;
    for (i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_valid[i] && (best < 0 || slot_rank[i] > slot_rank[best])) best = i;
    end
    return best;
  endfunction

  function automatic void drop_slot(int s);
    if (s >= 0) begin
      slot_valid[s] = 1'b0;
      slot_rank[s] = 0;
      if (entry_total > 0) entry_total--;
    end
  endfunction

  // Apply one get or put to the shadow store and work out its result.
  function automatic cache_result_t predict_op(logic is_put, logic [31:0] key,
                                               logic [31:0] val);
    cache_result_t res;
    int i;
    int hit;
    int target;
    int cap_eff;
    logic store_full;
    hit = -1;
    target = -1;
    store_full = 1'b0;
    cap_eff = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
    for (i = 0; i < MAX_ENTRIES; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
    end
    res.found = (hit >= 0);
    res.data = '0;
    if (!is_put) begin
      if (hit >= 0) begin
        promote(hit);
        res.data = slot_value[hit];
      end else begin
        res.data = MISS_DATA;
      end
    end else if (hit >= 0) begin
      slot_value[hit] = val;
      promote(hit);
    end else begin
      for (i = 0; i < MAX_ENTRIES; i++) begin
        if (target < 0 && !slot_valid[i]) target = i;
      end
      // A new key into a full store replaces the least recent entry.
      store_full = (target < 0);
      if (store_full) begin
        target = oldest_slot();
        drop_slot(target);
      end
      if (target >= 0) begin
        for (i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        slot_key[target] = key;
        slot_value[target] = val;
        slot_valid[target] = 1'b1;
        slot_rank[target] = 0;
        entry_total++;
      end
    end
    // A put evicts at most one entry when the count is over capacity.
    if (is_put && !store_full && entry_total > cap_eff) drop_slot(oldest_slot());
    return res;
  endfunction

  // Print one line per mismatch; printing stops after the first hundred.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Results are compared before new transactions are predicted in each cycle.
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i] = 0;
      end
      entry_total = 0;
      capacity = CAP_RESET;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none outstanding", '0, out_read_data);
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found) begin
            report_mismatch("found", 32'(want.found), 32'(out_found));
          end
          if (out_read_data !== want.data) report_mismatch("read_data", want.data, out_read_data);
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_active_capacity;
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_op(in_command == CMD_PUT, in_lookup_key,
                                              in_store_value));
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== sim/lru_key_value_cache_tb.sv =====
// Top of the LRU key/value cache testbench: clock, reset, get/put stimulus and
// capacity writes. Depends on lkv_pkg, lru_key_value_cache and its checker.
`timescale 1ns / 1ps

module lru_key_value_cache_tb import lkv_pkg::*;;

  localparam int MAX_ENTRIES = 16;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 60;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int POOL_MAX = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [31:0] in_lookup_key;
  logic [31:0] in_store_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic [31:0] out_read_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_active_capacity;

  int mismatches;
  int pending;

  // Stimulus controls; rx_idle_en and holds_asked are shared with the receiver process.
  logic tx_idle_en;
  logic rx_idle_en;
  int   holds_asked;

  int sent_count;
  int put_count;
  int cfg_writes;
  logic [4:0]  cur_capacity;
  logic [31:0] key_pool [POOL_MAX];
  int          pool_size;

  lru_key_value_cache #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_lookup_key       (in_lookup_key),
    .in_store_value      (in_store_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_read_data       (out_read_data),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_active_capacity (cfg_active_capacity)
  );

  lru_key_value_cache_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_lookup_key       (in_lookup_key),
    .in_store_value      (in_store_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_read_data       (out_read_data),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_active_capacity (cfg_active_capacity),
    .mismatch_count      (mismatches),
    .pending_results     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard limit on the run length.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("[lru_key_value_cache] ERROR");
    $finish;
  end

  // Result side: random stall bursts, plus long hold-offs on request.
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one transaction, after an optional idle gap, and wait for acceptance.
  task automatic send_item(input lkv_cmd_t cmd, input logic [31:0] key,
                           input logic [31:0] val);
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_lookup_key = key;
    in_store_value = val;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (cmd == CMD_PUT) put_count++;
  endtask

  // Stop offering transactions and wait until every result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Capacity writes happen only with the cache idle.
  task automatic write_capacity(input logic [4:0] cap);
    wait_for_results();
    cfg_active_capacity = cap;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_capacity = cap;
    cfg_writes++;
  endtask

  // Mostly keys from a small pool so that hits, updates and evictions occur.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [4:0] phase_caps [NUM_PHASES];
    int ph;
    int n;
    int cap_eff;
    lkv_cmd_t cmd;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_GET;
    in_lookup_key = '0;
    in_store_value = '0;
    cfg_valid = 1'b0;
    cfg_active_capacity = CAP_RESET;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    holds_asked = 0;
    sent_count = 0;
    put_count = 0;
    cfg_writes = 0;
    cur_capacity = CAP_RESET;
    pool_size = 1;
    key_pool[0] = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: miss on the empty store, extreme keys and values, hits, update.
    send_item(CMD_GET, 32'h0000_0000, $urandom);
    send_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_GET, 32'h8000_0000, $urandom);
    send_item(CMD_GET, 32'h7FFF_FFFF, $urandom);
    send_item(CMD_GET, 32'h1234_5678, $urandom);
    send_item(CMD_PUT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_item(CMD_GET, 32'hFFFF_FFFF, $urandom);

    // Capacity lowered below the count: gets keep it, each put trims by one.
    write_capacity(5'd2);
    send_item(CMD_GET, 32'h0000_0000, $urandom);
    send_item(CMD_PUT, 32'h0000_0005, 32'hA5A5_0005);
    send_item(CMD_PUT, 32'h0000_0005, 32'hA5A5_0006);
    send_item(CMD_PUT, 32'h0000_0005, 32'hA5A5_0007);
    send_item(CMD_GET, 32'h8000_0000, $urandom);

    // Capacity zero: each put evicts only the least recent entry, so a new key stays while older ones remain.
    write_capacity(5'd0);
    send_item(CMD_PUT, 32'h0000_0007, 32'h0000_0077);
    send_item(CMD_GET, 32'h0000_0007, $urandom);
    send_item(CMD_PUT, 32'h0000_0005, 32'h0000_0055);
    send_item(CMD_GET, 32'h0000_0005, $urandom);

    // Random phases, each under its own capacity setting.
    phase_caps[0] = 5'd31;
    phase_caps[1] = 5'd3;
    phase_caps[2] = 5'd1;
    phase_caps[3] = 5'd16;
    phase_caps[4] = 5'd0;
    phase_caps[5] = 5'($urandom_range(1, 15));
    phase_caps[6] = 5'd8;
    phase_caps[7] = 5'($urandom_range(0, 31));
    phase_caps[8] = 5'd16;
    phase_caps[9] = 5'd5;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      cap_eff = (cur_capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(cur_capacity);
      // A few more keys than fit, so that the store fills and evicts.
      pool_size = cap_eff + 4;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      for (n = 2; n < pool_size; n++) key_pool[n] = $urandom;
      // No idling in the last two phases; phases 1 and 2 idle on one side, the rest on both.
      tx_idle_en = (ph < NUM_PHASES - 2) && (ph != 1);
      rx_idle_en = (ph < NUM_PHASES - 2) && (ph != 2);
      // Long result hold-off while the sender keeps offering transactions.
      if (ph == 3) holds_asked++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) wait_for_results();
        cmd = lkv_cmd_t'($urandom_range(0, 1));
        send_item(cmd, pick_key(), pick_value());
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions (%0d puts, %0d gets) over %0d capacity writes,",
             sent_count, put_count, sent_count - put_count, cfg_writes);
    $display("covering capacities 0, 1, 16 and 31, full-store replacement and back-pressure.");
    if (mismatches == 0 && pending == 0) begin
      $display("[lru_key_value_cache] OK");
    end else begin
      $display("[lru_key_value_cache] ERROR");
    end
    $finish;
  end

endmodule
